// ----- rtl/u8d_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 stream decoder.
package u8d_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [20:0] REPL_CP  = 21'd63;
  localparam logic [20:0] MAX_CP   = 21'h10FFFF;
  localparam logic [20:0] SURR_LO  = 21'h00D800;
  localparam logic [20:0] SURR_HI  = 21'h00DFFF;
  localparam logic [20:0] MIN_TWO  = 21'h000080;
  localparam logic [20:0] MIN_THREE = 21'h000800;
  localparam logic [20:0] MIN_FOUR = 21'h010000;

  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } u8d_in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        replaced;
    logic        run_last;
    logic        text_done;
  } u8d_out_t;

  // One request from front to back: count results, all replacements but
  // the final one, which carries cp/rep.
  typedef struct packed {
    logic [2:0]  count;
    logic [20:0] cp;
    logic        rep;
    logic        done;
  } u8d_cmd_t;

  function automatic logic [20:0] min_for(input logic [2:0] len);
    logic [20:0] m;
    case (len)
      LEN_TWO:   m = MIN_TWO;
      LEN_THREE: m = MIN_THREE;
      default:   m = MIN_FOUR;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/u8d_front.sv -----
// Front end: accepts bytes, tracks the open sequence and builds result requests.
module u8d_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              text_valid,
  output logic              text_stall,
  input  u8d_pkg::u8d_in_t  text,
  input  logic              q_full,
  output logic              push,
  output u8d_pkg::u8d_cmd_t cmd
);

  logic [20:0] pv, pv_next;
  logic [2:0]  seq_len, seq_len_next;
  logic [1:0]  taken, taken_next;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic        is_cont;
  logic [20:0] pv_shift;
  logic [2:0]  taken_inc;
  logic        finish;
  logic        bad_value;
  logic [2:0]  lead_len;
  logic [20:0] lead_pv;
  logic [2:0]  k;

  assign text_stall = q_full;
  assign accept     = text_valid && !q_full;
  assign b          = text.text_byte;
  assign last       = text.text_end;
  assign is_cont    = (b[7:6] == 2'b10);
  assign pv_shift   = {pv[14:0], b[5:0]};
  assign taken_inc  = {1'b0, taken} + 3'd1;
  assign finish     = (taken_inc + 3'd1) >= seq_len;
  assign bad_value  = (pv_shift < u8d_pkg::min_for(seq_len)) || (pv_shift > u8d_pkg::MAX_CP)
                      || (pv_shift inside {[u8d_pkg::SURR_LO:u8d_pkg::SURR_HI]});
  assign k          = (seq_len != u8d_pkg::LEN_NONE) ? taken_inc : 3'd0;

  always_comb begin
    lead_len = u8d_pkg::LEN_NONE;
    lead_pv  = 21'd0;
    if (b inside {[8'hC0:8'hDF]}) begin
      lead_len = u8d_pkg::LEN_TWO;
      lead_pv  = {16'd0, b[4:0]};
    end else if (b inside {[8'hE0:8'hEF]}) begin
      lead_len = u8d_pkg::LEN_THREE;
      lead_pv  = {17'd0, b[3:0]};
    end else if (b inside {[8'hF0:8'hF7]}) begin
      lead_len = u8d_pkg::LEN_FOUR;
      lead_pv  = {18'd0, b[2:0]};
    end
  end

  always_comb begin
    pv_next      = pv;
    seq_len_next = seq_len;
    taken_next   = taken;
    cmd.count    = 3'd0;
    cmd.cp       = u8d_pkg::REPL_CP;
    cmd.rep      = 1'b1;
    cmd.done     = last;
    if (seq_len != u8d_pkg::LEN_NONE && is_cont) begin
      if (finish) begin
        if (bad_value) begin
          cmd.count = seq_len;
        end else begin
          cmd.count = 3'd1;
          cmd.cp    = pv_shift;
          cmd.rep   = 1'b0;
        end
        seq_len_next = u8d_pkg::LEN_NONE;
      end else if (last) begin
        cmd.count    = taken_inc + 3'd1;
        seq_len_next = u8d_pkg::LEN_NONE;
      end else begin
        pv_next    = pv_shift;
        taken_next = taken_inc[1:0];
      end
    end else begin
      // Flush the broken sequence, then treat the byte as a lead.
      cmd.count    = k;
      seq_len_next = u8d_pkg::LEN_NONE;
      taken_next   = 2'd0;
      if (!b[7]) begin
        cmd.count = k + 3'd1;
        cmd.cp    = {13'd0, b};
        cmd.rep   = 1'b0;
      end else if (lead_len != u8d_pkg::LEN_NONE) begin
        if (last) begin
          cmd.count = k + 3'd1;
        end else begin
          seq_len_next = lead_len;
          pv_next      = lead_pv;
        end
      end else begin
        cmd.count = k + 3'd1;
      end
    end
    if (last) begin
      pv_next      = 21'd0;
      seq_len_next = u8d_pkg::LEN_NONE;
      taken_next   = 2'd0;
    end
  end

  assign push = accept && (cmd.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv      <= 21'd0;
      seq_len <= u8d_pkg::LEN_NONE;
      taken   <= 2'd0;
    end else if (accept) begin
      pv      <= pv_next;
      seq_len <= seq_len_next;
      taken   <= taken_next;
    end
  end

`ifndef SYNTH
  a_taken_in_range: assert property (@(posedge clk) disable iff (rst)
    seq_len != u8d_pkg::LEN_NONE |-> ({1'b0, taken} + 3'd2) <= seq_len)
    else $error("continuation count outruns open sequence");
`endif

endmodule

// ----- rtl/u8d_queue.sv -----
// Short request queue between the front and back ends.
module u8d_queue #(
  parameter int unsigned DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8d_pkg::u8d_cmd_t wr_data,
  input  logic              pop,
  output u8d_pkg::u8d_cmd_t rd_data,
  output logic              full,
  output logic              empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  u8d_pkg::u8d_cmd_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("request queue overrun or underrun");
`endif

endmodule

// ----- rtl/u8d_back.sv -----
// Back end: expands each request into result items behind an output register.
module u8d_back (
  input  logic              clk,
  input  logic              rst,
  input  u8d_pkg::u8d_cmd_t head,
  input  logic              head_valid,
  output logic              pop,
  output logic              point_valid,
  input  logic              point_stall,
  output u8d_pkg::u8d_out_t point
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;

  assign load    = head_valid && (!point_valid || !point_stall);
  assign is_last = (({1'b0, idx} + 3'd1) == head.count);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
      idx         <= 2'd0;
    end else begin
      if (load) begin
        point_valid <= 1'b1;
        idx         <= is_last ? 2'd0 : idx + 2'd1;
      end else if (!point_stall) begin
        point_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      point.code_point <= is_last ? head.cp : u8d_pkg::REPL_CP;
      point.replaced   <= is_last ? head.rep : 1'b1;
      point.run_last   <= is_last;
      point.text_done  <= is_last && head.done;
    end
  end

`ifndef SYNTH
  a_done_is_run_last: assert property (@(posedge clk) disable iff (rst)
    point_valid && point.text_done |-> point.run_last)
    else $error("text end flagged on a result that is not last of its byte");
  a_scalar_is_run_last: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point.replaced |-> point.run_last)
    else $error("decoded scalar not last of its byte");
  a_replacement_value: assert property (@(posedge clk) disable iff (rst)
    point_valid && point.replaced |-> point.code_point == u8d_pkg::REPL_CP)
    else $error("replacement carries wrong code point");
  a_partial_has_head: assert property (@(posedge clk) disable iff (rst)
    idx != 2'd0 |-> head_valid)
    else $error("request left the queue while partly expanded");
`endif

endmodule

// ----- rtl/utf8_stream_decoder.sv -----
// Top level of the streaming UTF-8 decoder: front end, request queue, back end.
//
// Usage:
//   Input channel text_valid / text_stall / text carries one byte of UTF-8
//   text per request, with text_end set on the last byte of a text. Output
//   channel point_valid / point_stall / point carries decoded code points;
//   replaced marks a '?' standing in for a bad byte, run_last marks the last
//   result caused by one input byte, text_done marks the last result of a text.
//   A byte's request is written into the queue when it is accepted, and the
//   back end's output register then takes its results. Unless stalled, the
//   decoder takes one byte per cycle while each byte gives at most one result;
//   breaking bytes give up to four, one per cycle, set by the single output register.
//   Bytes that only open or extend a sequence give no result at all.
//   The front end stalls the input only when the request queue (QUEUE_DEPTH
//   entries) is full, so a stalled receiver backs up into the queue first.
//   While point_stall is high the presented result holds.
//   Reset (rst, synchronous) closes any open sequence and empties the queue
//   and the output register; the first byte after reset is read as a lead.
module utf8_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              text_valid,
  output logic              text_stall,
  input  u8d_pkg::u8d_in_t  text,
  output logic              point_valid,
  input  logic              point_stall,
  output u8d_pkg::u8d_out_t point
);

  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  u8d_pkg::u8d_cmd_t front_cmd;
  u8d_pkg::u8d_cmd_t head_cmd;

  // Classify bytes and track the open sequence.
  u8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text),
    .q_full     (q_full),
    .push       (push),
    .cmd        (front_cmd)
  );

  // Hold requests so the two sides stall independently.
  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_cmd),
    .pop     (pop),
    .rd_data (head_cmd),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Expand each request into its result items.
  u8d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_cmd),
    .head_valid  (!q_empty),
    .pop         (pop),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point)
  );

endmodule

// ----- tb/sv/utf8_point_checker.sv -----
// Predicts and checks the code points of the UTF-8 stream decoder from its two channels.
module utf8_point_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              text_valid,
  input  logic              text_stall,
  input  u8d_pkg::u8d_in_t  text,
  input  logic              point_valid,
  input  logic              point_stall,
  input  u8d_pkg::u8d_out_t point,
  output int                fail_count,
  output int                expected_left
);

  localparam int MAX_PER_BYTE = 4;

  // Decoder state as seen by the prediction.
  logic [20:0] acc_bits = '0;
  logic [2:0]  open_len = u8d_pkg::LEN_NONE;
  logic [1:0]  cont_seen = '0;

  u8d_pkg::u8d_out_t step_out[$];
  u8d_pkg::u8d_out_t points_due[$];
  int                errors = 0;

  function automatic void drop_sequence();
    acc_bits = '0;
    open_len = u8d_pkg::LEN_NONE;
    cont_seen = '0;
  endfunction

  function automatic void add_point(input logic [20:0] cp, input logic rep);
    u8d_pkg::u8d_out_t p;
    p = '{code_point: cp, replaced: rep, run_last: 1'b0, text_done: 1'b0};
    step_out.insert(step_out.size(), p);
  endfunction

  // Add up to n replacements, never more than one byte can cause.
  function automatic void add_repl(input int n);
    for (int i = 0; i < n && step_out.size() < MAX_PER_BYTE; i++)
      add_point(u8d_pkg::REPL_CP, 1'b1);
  endfunction

  // Work out the results of one accepted request and queue them.
  task automatic decode_byte(input u8d_pkg::u8d_in_t req);
    logic [7:0]  b;
    logic [1:0]  taken;
    logic [20:0] lowest;
    logic        used;
    b = req.text_byte;
    used = 1'b0;
    step_out.delete();

    if (open_len != u8d_pkg::LEN_NONE) begin
      if (b[7:6] == 2'b10) begin
        used = 1'b1;
        taken = cont_seen + 2'd1;
        acc_bits = {acc_bits[14:0], b[5:0]};
        if ({1'b0, taken} + 3'd1 >= open_len) begin
          lowest = (open_len == u8d_pkg::LEN_TWO) ? u8d_pkg::MIN_TWO :
                   (open_len == u8d_pkg::LEN_THREE) ? u8d_pkg::MIN_THREE :
                   u8d_pkg::MIN_FOUR;
          if (acc_bits < lowest || acc_bits > u8d_pkg::MAX_CP ||
              (acc_bits >= u8d_pkg::SURR_LO && acc_bits <= u8d_pkg::SURR_HI))
            add_repl(int'(open_len));
          else
            add_point(acc_bits, 1'b0);
          drop_sequence();
        end else if (req.text_end) begin
          add_repl(int'(taken) + 1);
          drop_sequence();
        end else begin
          cont_seen = taken;
        end
      end else begin
        // Broken sequence: replace what was taken, then reread the byte as a lead.
        add_repl(int'(cont_seen) + 1);
        drop_sequence();
      end
    end

    if (!used) begin
      if (b[7] == 1'b0) begin
        add_point({13'd0, b}, 1'b0);
      end else if (b[7:5] == 3'b110) begin
        open_len = u8d_pkg::LEN_TWO;
        acc_bits = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        open_len = u8d_pkg::LEN_THREE;
        acc_bits = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        open_len = u8d_pkg::LEN_FOUR;
        acc_bits = {18'd0, b[2:0]};
      end else begin
        add_repl(1);
      end
      cont_seen = '0;
      if (req.text_end && open_len != u8d_pkg::LEN_NONE) begin
        add_repl(1);
        drop_sequence();
      end
    end

    if (req.text_end)
      drop_sequence();

    if (step_out.size() > 0) begin
      step_out[step_out.size() - 1].run_last = 1'b1;
      step_out[step_out.size() - 1].text_done = req.text_end;
    end
    foreach (step_out[i])
      points_due.insert(points_due.size(), step_out[i]);
  endtask

  always @(posedge clk) begin : watch
    u8d_pkg::u8d_out_t want;
    if (rst) begin
      drop_sequence();
      points_due.delete();
    end else begin
      if (text_valid && !text_stall)
        decode_byte(text);
      if (point_valid && !point_stall) begin
        if (points_due.size() == 0) begin
          $error("unexpected result: code_point %0h replaced %0b", point.code_point,
                 point.replaced);
          errors++;
        end else begin
          want = points_due.pop_front();
          if (point.code_point !== want.code_point) begin
            $error("code_point: expected %0h, got %0h", want.code_point, point.code_point);
            errors++;
          end
          if (point.replaced !== want.replaced) begin
            $error("replaced: expected %0b, got %0b", want.replaced, point.replaced);
            errors++;
          end
          if (point.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, point.run_last);
            errors++;
          end
          if (point.text_done !== want.text_done) begin
            $error("text_done: expected %0b, got %0b", want.text_done, point.text_done);
            errors++;
          end
        end
      end
    end
    expected_left <= points_due.size();
    fail_count <= errors;
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the UTF-8 stream decoder test: clock, reset, byte stimulus, receiver and verdict.
module testbench;

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 60;
  localparam int SETTLE_CYCLES = 20;

  logic              clk;
  logic              rst;
  logic              text_valid;
  logic              text_stall;
  u8d_pkg::u8d_in_t  text;
  logic              point_valid;
  logic              point_stall;
  u8d_pkg::u8d_out_t point;

  int fail_count;
  int expected_left;

  // Knobs shared by the sender and the receiver processes.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_point     = 1'b0;
  int sent           = 0;

  logic [7:0] seq_bytes[$];

  utf8_stream_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text        (text),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point)
  );

  utf8_point_checker point_check (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_stall    (text_stall),
    .text          (text),
    .point_valid   (point_valid),
    .point_stall   (point_stall),
    .point         (point),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hung run; far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: stall at random, or hold off for a long stretch on request.
  initial begin
    point_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_point) begin
        point_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_point = 1'b0;
      end else begin
        point_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one byte, idling first at random; return at the edge that accepts it.
  task automatic offer(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid <= 1'b1;
    text <= '{text_byte: b, text_end: fin};
    @(posedge clk);
    while (text_stall) @(posedge clk);
    sent++;
  endtask

  // Drop valid and hold until every predicted result has come out.
  task automatic wait_drained();
    text_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  function automatic void append_byte(input logic [7:0] b);
    seq_bytes.insert(seq_bytes.size(), b);
  endfunction

  // Build the len-byte encoding of v, overlong or out of range if asked to.
  task automatic encode(input int len, input logic [20:0] v);
    seq_bytes.delete();
    case (len)
      1: append_byte({1'b0, v[6:0]});
      2: begin
        append_byte({3'b110, v[10:6]});
        append_byte({2'b10, v[5:0]});
      end
      3: begin
        append_byte({4'b1110, v[15:12]});
        append_byte({2'b10, v[11:6]});
        append_byte({2'b10, v[5:0]});
      end
      default: begin
        append_byte({5'b11110, v[20:18]});
        append_byte({2'b10, v[17:12]});
        append_byte({2'b10, v[11:6]});
        append_byte({2'b10, v[5:0]});
      end
    endcase
  endtask

  // One random piece of text: mostly well-formed, the rest malformed or noise.
  task automatic offer_piece();
    int          kind;
    int          len;
    int          noise;
    logic [20:0] v;
    logic        fin;
    kind = $urandom_range(99);
    len = $urandom_range(4, 1);
    case (len)
      1: v = 21'($urandom_range(8'h7F));
      2: v = 21'($urandom_range(11'h7FF, 8'h80));
      3: v = 21'($urandom_range(16'hFFFF, 12'h800));
      default: v = 21'($urandom_range(21'h10FFFF, 17'h10000));
    endcase
    fin = ($urandom_range(99) < 12);

    if (kind < 65) begin
      encode(len, v);
    end else if (kind < 73) begin
      // Overlong: squeeze the value into a longer form than it needs.
      if (len < 4) len = $urandom_range(4, len + 1);
      encode(len, v);
    end else if (kind < 79) begin
      encode(4, 21'($urandom_range(21'h1FFFFF, 21'h110000)));
    end else if (kind < 83) begin
      encode(3, 21'($urandom_range(16'hDFFF, 16'hD800)));
    end else if (kind < 92) begin
      // Cut the sequence short; either the text ends or the next piece's bytes follow it.
      if (len < 2) len = $urandom_range(4, 2);
      encode(len, v);
      repeat ($urandom_range(len - 1, 1)) void'(seq_bytes.pop_back());
      fin = 1'($urandom_range(1));
    end else begin
      seq_bytes.delete();
      noise = $urandom_range(3, 1);
      repeat (noise) append_byte(8'($urandom_range(255)));
    end

    foreach (seq_bytes[i])
      offer(seq_bytes[i], fin && (i == seq_bytes.size() - 1));
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    int target;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = sent + count;
    while (sent < target) offer_piece();
  endtask

  initial begin
    rst <= 1'b1;
    text_valid <= 1'b0;
    text <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes and each special case.
    offer(8'h00, 1'b0);
    offer(8'h7F, 1'b1);                               // ASCII ends a text
    offer(8'hC2, 1'b0); offer(8'h80, 1'b0);           // smallest two-byte
    offer(8'hE0, 1'b0); offer(8'hA0, 1'b0); offer(8'h80, 1'b0);
    offer(8'hF4, 1'b0); offer(8'h8F, 1'b0);           // largest scalar
    offer(8'hBF, 1'b0); offer(8'hBF, 1'b1);
    offer(8'h80, 1'b0);                               // stray continuation
    offer(8'hFF, 1'b0);                               // invalid lead
    offer(8'hF5, 1'b0); offer(8'h80, 1'b0);           // lead above the range
    offer(8'h80, 1'b0); offer(8'h80, 1'b0);
    offer(8'hC0, 1'b0); offer(8'h80, 1'b0);           // always overlong
    offer(8'hED, 1'b0); offer(8'hA0, 1'b0); offer(8'h80, 1'b0);  // surrogate
    offer(8'hE2, 1'b0); offer(8'h41, 1'b0);           // broken by ASCII
    offer(8'hF0, 1'b0); offer(8'h90, 1'b1);           // cut off by the end
    offer(8'hC3, 1'b1);                               // lead as final byte
    wait_drained();

    run_phase(0, 0, PHASE_BYTES);

    // Long receiver hold-off while the sender keeps offering: fill the queue.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_point = 1'b1;
    repeat (40) offer(8'($urandom_range(8'h7E, 8'h20)), 1'b0);

    run_phase(51, 0, PHASE_BYTES);
    wait_drained();
    run_phase(0, 51, PHASE_BYTES);
    run_phase(25, 25, PHASE_BYTES);

    // Close the last text so nothing stays open, then drain.
    offer(8'h0A, 1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_left == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
